### rtl/core/hash_map_insert_lookup_top_assert.svh
// assertion macros for the hash map insert/lookup block
`ifndef HASH_MAP_INSERT_LOOKUP_TOP_ASSERT_SVH
`define HASH_MAP_INSERT_LOOKUP_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HMIL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define HMIL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/hmil_pkg.sv
// shared constants and types for the hash map insert/lookup block
package hmil_pkg;

    localparam int KEY_W      = 32;
    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int CFG_W      = 5;
    localparam int DIV_CNT_W  = $clog2(KEY_W);

    localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = CFG_W'(10);

    localparam int DEF_BUCKETS     = 16;
    localparam int DEF_CHAIN_DEPTH = 8;
    localparam int DEF_VALUE_BITS  = 32;

    localparam int S_TDATA_W = ((KEY_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + 7) / 8) * 8;
    localparam int M_TUSER_W = STATUS_W;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_HIT       = 3'd3,
        ST_MISS      = 3'd4
    } t_status;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

endpackage

### rtl/core/hmil_ram.sv
// generic single-write, single-read ram with registered read data
module hmil_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/hash_map_insert_lookup_top.sv
// top level of the hash map insert/lookup block
// Key-value table with separate chaining. Each input transaction is an insert
// (tuser = 0) or a lookup (tuser = 1) of a 32-bit unsigned key; each produces
// exactly one output transaction carrying a status code in tuser (0 inserted,
// 1 duplicate ignored, 2 bucket full dropped, 3 lookup hit, 4 lookup miss) and
// the stored value in tdata on a lookup hit, zero otherwise. The bucket is the
// key modulo the configured bucket count (0 acts as 1, values above BUCKETS
// act as BUCKETS). Changing the count while entries are held does not move
// them. An item passes from acceptance to its result through the bit-serial
// restoring divider that forms the bucket, the chain-length memory read, a
// key/value memory read and compare for each chain entry up to the match (at
// most CHAIN_DEPTH entries), one more step to see the end of the chain when
// no entry matches, and the write back that loads the output register.
// One item is worked on at a time; a finished result may wait in the output
// register while the next item is accepted, and a result that finds the
// register still full waits until it drains. After reset a clearing pass
// zeroes the chain lengths, one bucket per cycle, during which no item is
// accepted (configuration writes still land).
module hash_map_insert_lookup_top #(
    parameter int BUCKETS     = hmil_pkg::DEF_BUCKETS,
    parameter int CHAIN_DEPTH = hmil_pkg::DEF_CHAIN_DEPTH,
    parameter int VALUE_BITS  = hmil_pkg::DEF_VALUE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration: bucket_count
    input  logic                           i_cfg_we,
    input  logic [hmil_pkg::CFG_W-1:0]     i_cfg_wdata,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [hmil_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [31:0] key, [63:32] value
    input  logic                           s_axis_tuser,  // [0] op
    // output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [hmil_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [31:0] found_value
    output logic [hmil_pkg::M_TUSER_W-1:0] m_axis_tuser   // [2:0] status
);

    import hmil_pkg::*;

    // bucket index, chain slot and chain length widths
    localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SLOT_W = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
    localparam int LEN_W  = $clog2(CHAIN_DEPTH + 1);
    localparam int ENT_AW = BKT_W + SLOT_W;

    localparam logic [LEN_W-1:0] LEN_FULL    = LEN_W'(CHAIN_DEPTH);
    localparam logic [BKT_W-1:0] LAST_BUCKET = BKT_W'(BUCKETS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,    // zero chain lengths after reset
        S_IDLE,     // wait for an input transaction
        S_DIV,      // one quotient bit per cycle, remainder is the bucket
        S_LEN_RD,   // read the bucket's chain length
        S_LEN_CAP,  // capture chain length
        S_WALK,     // issue read of the next chain slot
        S_CHECK,    // compare stored key
        S_FINISH    // write back and load the output register
    } t_state;

    t_state                 r_state;
    logic [CFG_W-1:0]       r_bucket_count;
    logic [CFG_W-1:0]       r_div;
    logic [CFG_W-1:0]       r_rem;
    logic [KEY_W-1:0]       r_dividend;
    logic [DIV_CNT_W-1:0]   r_div_cnt;
    logic [BKT_W-1:0]       r_clr_idx;
    logic                   r_op;
    logic [KEY_W-1:0]       r_key;
    logic [VALUE_BITS-1:0]  r_value;
    logic [BKT_W-1:0]       r_bucket;
    logic [LEN_W-1:0]       r_len;
    logic [LEN_W-1:0]       r_slot;
    logic                   r_found;
    logic [DATA_W-1:0]      r_hit_val;
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [DATA_W-1:0]      r_out_data;

    // effective divisor
    logic [CFG_W-1:0] eff_div;

    // divider step
    logic [CFG_W:0]   rem_shift;
    logic [CFG_W:0]   rem_sub;
    logic [CFG_W-1:0] rem_nx;

    // memory ports
    logic              len_we;
    logic [BKT_W-1:0]  len_waddr;
    logic [LEN_W-1:0]  len_wdata;
    logic [LEN_W-1:0]  len_rdata;
    logic              ent_we;
    logic [ENT_AW-1:0] ent_waddr;
    logic [ENT_AW-1:0] ent_raddr;
    logic [KEY_W-1:0]      key_rdata;
    logic [VALUE_BITS-1:0] val_rdata;

    logic    out_load;
    logic    do_append;
    t_status fin_status;

    // terms for the checks at the end
    logic in_accept;
    logic out_nonhit;
    logic walk_busy;
    logic walk_in_range;

    always_comb begin
        if (r_bucket_count == '0) begin
            eff_div = CFG_W'(1);
        end else if (32'(r_bucket_count) > BUCKETS) begin
            eff_div = CFG_W'(BUCKETS);
        end else begin
            eff_div = r_bucket_count;
        end
    end

    // restoring division: remainder stays below the divisor
    assign rem_shift = {r_rem, r_dividend[KEY_W-1]};
    assign rem_sub   = rem_shift - {1'b0, r_div};
    assign rem_nx    = (rem_shift >= {1'b0, r_div}) ? rem_sub[CFG_W-1:0]
                                                    : rem_shift[CFG_W-1:0];

    assign out_load  = (r_state == S_FINISH) && (!r_out_valid || m_axis_tready);
    assign do_append = (r_op == OP_INSERT) && !r_found && (r_len != LEN_FULL);

    always_comb begin
        if (r_op == OP_LOOKUP) begin
            fin_status = r_found ? ST_HIT : ST_MISS;
        end else if (r_found) begin
            fin_status = ST_DUPLICATE;
        end else if (r_len == LEN_FULL) begin
            fin_status = ST_FULL;
        end else begin
            fin_status = ST_INSERTED;
        end
    end

    // chain length memory: cleared by the sweep, bumped on append
    assign len_we    = (r_state == S_CLEAR) || (out_load && do_append);
    assign len_waddr = (r_state == S_CLEAR) ? r_clr_idx : r_bucket;
    assign len_wdata = (r_state == S_CLEAR) ? '0 : r_len + LEN_W'(1);

    // entry memories: slot j of bucket b sits at {b, j}
    assign ent_we    = out_load && do_append;
    assign ent_waddr = {r_bucket, r_len[SLOT_W-1:0]};
    assign ent_raddr = {r_bucket, r_slot[SLOT_W-1:0]};

    hmil_ram #(
        .WIDTH  (LEN_W),
        .DEPTH  (BUCKETS),
        .ADDR_W (BKT_W)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_raddr (r_bucket),
        .o_rdata (len_rdata)
    );

    hmil_ram #(
        .WIDTH  (KEY_W),
        .DEPTH  (2 ** ENT_AW),
        .ADDR_W (ENT_AW)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (r_key),
        .i_raddr (ent_raddr),
        .o_rdata (key_rdata)
    );

    hmil_ram #(
        .WIDTH  (VALUE_BITS),
        .DEPTH  (2 ** ENT_AW),
        .ADDR_W (ENT_AW)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (r_value),
        .i_raddr (ent_raddr),
        .o_rdata (val_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_bucket_count <= BUCKET_COUNT_RESET;
            r_clr_idx      <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_bucket_count <= i_cfg_wdata;
            end

            // output register: a new result refills it, otherwise it drains
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + BKT_W'(1);
                    if (r_clr_idx == LAST_BUCKET) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op       <= s_axis_tuser;
                        r_key      <= s_axis_tdata[KEY_W-1:0];
                        r_value    <= VALUE_BITS'(s_axis_tdata[KEY_W +: DATA_W]);
                        r_dividend <= s_axis_tdata[KEY_W-1:0];
                        r_div      <= eff_div;
                        r_rem      <= '0;
                        r_div_cnt  <= DIV_CNT_W'(KEY_W - 1);
                        r_found    <= 1'b0;
                        r_hit_val  <= '0;
                        r_state    <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem      <= rem_nx;
                    r_dividend <= {r_dividend[KEY_W-2:0], 1'b0};
                    r_div_cnt  <= r_div_cnt - DIV_CNT_W'(1);
                    if (r_div_cnt == '0) begin
                        r_bucket <= BKT_W'(rem_nx);
                        r_state  <= S_LEN_RD;
                    end
                end
                S_LEN_RD: begin
                    r_state <= S_LEN_CAP;
                end
                S_LEN_CAP: begin
                    r_len   <= len_rdata;
                    r_slot  <= '0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (r_slot == r_len) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (key_rdata == r_key) begin
                        r_found   <= 1'b1;
                        r_hit_val <= DATA_W'(val_rdata);
                        r_state   <= S_FINISH;
                    end else begin
                        r_slot  <= r_slot + LEN_W'(1);
                        r_state <= S_WALK;
                    end
                end
                S_FINISH: begin
                    if (out_load) begin
                        r_out_status <= fin_status;
                        r_out_data   <= (fin_status == ST_HIT) ? r_hit_val : '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out_data);
    assign m_axis_tuser  = r_out_status;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_nonhit    = m_axis_tvalid && (m_axis_tuser != ST_HIT);
    assign walk_busy     = (r_state == S_WALK) || (r_state == S_CHECK);
    assign walk_in_range = (r_len <= LEN_FULL) && (r_slot <= r_len);

`include "hash_map_insert_lookup_top_assert.svh"

    // an accepted item keeps the input closed while it is worked on
    `HMIL_ASSERT_NEXT(a_busy_after_accept, in_accept, !s_axis_tready, "input open after accept")

    // only a lookup hit carries a nonzero value
    `HMIL_ASSERT_NOW(a_value_only_on_hit, out_nonhit, m_axis_tdata == '0, "value on non-hit")

    // chain walk stays inside the bucket's filled slots
    `HMIL_ASSERT_NOW(a_walk_bounds, walk_busy, walk_in_range, "chain walk out of bounds")

    // a result never overwrites one that is still waiting
    `HMIL_ASSERT_NOW(a_no_overwrite, out_load, !r_out_valid || m_axis_tready, "result lost")

endmodule

### sim/hash_map_insert_lookup_top_tb.sv
// self-checking testbench for the hash map insert/lookup block
module hash_map_insert_lookup_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hmil_pkg::*;

    localparam int BKT_MAX    = DEF_BUCKETS;
    localparam int SLOT_DEPTH = DEF_CHAIN_DEPTH;
    localparam int SLOT_COUNT = BKT_MAX * SLOT_DEPTH;
    // settle time: covers a worst case item at full chain depth, plus margin
    localparam int SETTLE_CYCLES = 36 + 2 * SLOT_DEPTH + 12;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 200;
    localparam int POOL_SIZE     = 16;

    typedef struct {
        t_status           status;
        logic [DATA_W-1:0] found_value;
    } t_table_result;

    // mirror of the table contents plus the results still owed by the block
    class hash_table_scoreboard;
        logic [CFG_W-1:0]  bucket_cfg;
        logic [3:0]        chain_len [BKT_MAX];
        logic [KEY_W-1:0]  slot_key [SLOT_COUNT];
        logic [DATA_W-1:0] slot_val [SLOT_COUNT];
        t_table_result     owed_q[$];
        int                errors;

        function new();
            bucket_cfg = BUCKET_COUNT_RESET;
            foreach (chain_len[i]) chain_len[i] = '0;
            errors = 0;
        endfunction

        function void set_bucket_count(logic [CFG_W-1:0] v);
            bucket_cfg = v;
        endfunction

        // apply one accepted request to the mirror and queue its result
        function void note_request(t_op op, logic [KEY_W-1:0] key, logic [DATA_W-1:0] value);
            int unsigned       nbkt;
            int unsigned       bkt;
            int unsigned       len;
            int unsigned       base;
            int unsigned       j;
            bit                hit;
            logic [DATA_W-1:0] hit_val;
            t_table_result     res;
            nbkt = bucket_cfg;
            if (nbkt == 0) nbkt = 1;
            if (nbkt > BKT_MAX) nbkt = BKT_MAX;
            bkt = key % nbkt;
            len = chain_len[bkt];
            if (len > SLOT_DEPTH) len = SLOT_DEPTH;
            base = bkt * SLOT_DEPTH;
            hit = 1'b0;
            hit_val = '0;
            for (j = 0; j < len && !hit; j++) begin
                if (slot_key[base + j] == key) begin
                    hit = 1'b1;
                    hit_val = slot_val[base + j];
                end
            end
            if (op == OP_INSERT) begin
                if (hit) begin
                    res.status = ST_DUPLICATE;
                end else if (len >= SLOT_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    slot_key[base + len] = key;
                    slot_val[base + len] = value;
                    chain_len[bkt] = 4'(len + 1);
                    res.status = ST_INSERTED;
                end
                res.found_value = '0;
            end else begin
                res.status = hit ? ST_HIT : ST_MISS;
                res.found_value = hit ? hit_val : '0;
            end
            owed_q = {owed_q, res};
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [STATUS_W-1:0] status, logic [DATA_W-1:0] value);
            t_table_result res;
            if (owed_q.size() == 0) begin
                report_mismatch($sformatf("result status %0d with nothing pending", status));
            end else begin
                res = owed_q.pop_front();
                if (status !== res.status)
                    report_mismatch($sformatf("status %0d, want %0d", status, res.status));
                if (value !== res.found_value)
                    report_mismatch($sformatf("found_value %h, want %h", value,
                                              res.found_value));
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    hash_table_scoreboard sb;

    // idle percentages for the two sides, and a long receiver hold-off
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int hold_cycles   = 0;

    hash_map_insert_lookup_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] key, [63:32] value
        .s_axis_tuser  (s_axis_tuser),   // [0] op
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] found_value
        .m_axis_tuser  (m_axis_tuser)    // [2:0] status
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // offer one request; valid stays high afterwards so back-to-back
    // transactions need no gap, the caller drops it at the end of a burst
    task automatic send_item(input t_op op, input logic [KEY_W-1:0] key,
                             input logic [DATA_W-1:0] value);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, key};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(op, key, value);
    endtask

    // hold until every owed result has come back, then let the block settle
    task automatic wait_for_results(input int settle);
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // bucket count write, only issued while the block is idle
    task automatic write_bucket_count(input logic [CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_bucket_count(v);
    endtask

    // result side: check each accepted transaction, then pick next tready
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata);
            if (hold_cycles > 0) begin
                // long hold-off so the block backs up and stalls its input
                hold_cycles   = hold_cycles - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // main stimulus
    initial begin
        logic [CFG_W-1:0] cfg_v;
        logic [KEY_W-1:0] key_pool [POOL_SIZE];
        logic [KEY_W-1:0] key;
        t_op              op;
        int               k;

        sb = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_INSERT;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset bucket count of ten
        send_item(OP_LOOKUP, 32'h0, 32'hFFFF_FFFF);          // miss on empty table
        send_item(OP_INSERT, 32'h0, 32'h0);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_LOOKUP, 32'h0, 32'h0);
        send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_item(OP_INSERT, 32'h0, 32'hA5A5_A5A5);          // duplicate keeps old value
        send_item(OP_LOOKUP, 32'h0, 32'h5A5A_5A5A);
        // fill bucket three to its depth, the last insert is dropped
        for (k = 0; k <= SLOT_DEPTH; k++)
            send_item(OP_INSERT, 32'(3 + 10 * k), 32'h1000 + 32'(k));
        send_item(OP_LOOKUP, 32'(3 + 10 * SLOT_DEPTH), 32'h0);   // dropped key misses
        send_item(OP_LOOKUP, 32'(3 + 10 * (SLOT_DEPTH - 1)), 32'h0);  // deepest entry
        send_item(OP_LOOKUP, 32'd3, 32'h0);
        send_item(OP_LOOKUP, 32'h8000_0000, 32'h0);
        send_item(OP_INSERT, 32'h8000_0000, 32'h8000_0001);
        send_item(OP_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF);
        s_axis_tvalid <= 1'b0;
        wait_for_results(SETTLE_CYCLES);

        // random phases, each at its own bucket count and idle pattern
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: cfg_v = 5'd1;
                1: cfg_v = 5'd0;     // zero acts as a single bucket
                2: cfg_v = 5'd31;    // saturates to the bucket limit
                3: cfg_v = 5'd2;
                4: cfg_v = 5'd16;
                5: cfg_v = 5'd17;
                6: cfg_v = 5'd7;
                8: cfg_v = 5'd13;
                default: cfg_v = 5'($urandom_range(0, 31));
            endcase
            write_bucket_count(cfg_v);

            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 54; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 54; end
                default: begin src_idle_pct = 35; sink_stall_pct = 35; end
            endcase

            // small set of keys per phase so lookups hit and inserts collide
            foreach (key_pool[i]) begin
                case ($urandom_range(0, 3))
                    0: key_pool[i] = 32'($urandom_range(0, 40));
                    1: key_pool[i] = 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
                    default: key_pool[i] = $urandom;
                endcase
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 0 && n == 20)
                    hold_cycles = 400;
                if (n == PHASE_ITEMS / 2) begin
                    // sender pause until the block has answered everything
                    s_axis_tvalid <= 1'b0;
                    while (sb.owed_q.size() != 0) @(posedge i_clk);
                end
                op  = t_op'($urandom_range(0, 1));
                key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                   : $urandom;
                send_item(op, key, $urandom);
            end
            s_axis_tvalid <= 1'b0;
            wait_for_results(SETTLE_CYCLES);
        end

        if (sb.owed_q.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.owed_q.size()));
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
